[src/slx_pkg.sv]
// ----------------------------------------------------------------------------
// slx_pkg: shared types and constants of the script lexer
// Token kinds, error codes, scan modes, the result item and the keyword table.
// ----------------------------------------------------------------------------
package slx_pkg;

	localparam int MaxResults = 4;
	localparam int QueueDepth = 2;

	localparam logic [5:0] K_LPAREN  = 6'd0;
	localparam logic [5:0] K_RPAREN  = 6'd1;
	localparam logic [5:0] K_LBRACE  = 6'd2;
	localparam logic [5:0] K_RBRACE  = 6'd3;
	localparam logic [5:0] K_COMMA   = 6'd4;
	localparam logic [5:0] K_DOT     = 6'd5;
	localparam logic [5:0] K_MINUS   = 6'd6;
	localparam logic [5:0] K_PLUS    = 6'd7;
	localparam logic [5:0] K_SEMI    = 6'd8;
	localparam logic [5:0] K_SLASH   = 6'd9;
	localparam logic [5:0] K_STAR    = 6'd10;
	localparam logic [5:0] K_BANG    = 6'd11;
	localparam logic [5:0] K_BANG_EQ = 6'd12;
	localparam logic [5:0] K_EQUAL   = 6'd13;
	localparam logic [5:0] K_EQ_EQ   = 6'd14;
	localparam logic [5:0] K_GREATER = 6'd15;
	localparam logic [5:0] K_GT_EQ   = 6'd16;
	localparam logic [5:0] K_LESS    = 6'd17;
	localparam logic [5:0] K_LT_EQ   = 6'd18;
	localparam logic [5:0] K_IDENT   = 6'd19;
	localparam logic [5:0] K_STRING  = 6'd20;
	localparam logic [5:0] K_NUMBER  = 6'd21;
	localparam logic [5:0] K_KEYWORD0 = 6'd22;
	localparam logic [5:0] K_EOF     = 6'd38;

	localparam logic [1:0] E_NONE    = 2'd0;
	localparam logic [1:0] E_ILLEGAL = 2'd1;
	localparam logic [1:0] E_UNTERM  = 2'd2;

	localparam logic [7:0] C_NL    = 8'h0A;
	localparam logic [7:0] C_CR    = 8'h0D;
	localparam logic [7:0] C_QUOTE = 8'h22;
	localparam logic [7:0] C_DOT   = 8'h2E;
	localparam logic [7:0] C_SLASH = 8'h2F;
	localparam logic [7:0] C_EQ    = 8'h3D;
	localparam logic [7:0] C_UNDER = 8'h5F;

	typedef enum logic [3:0] {
		M_IDLE, M_SLASH, M_BANG, M_EQUAL, M_GREATER, M_LESS, M_COMMENT,
		M_STRING, M_INT, M_DOT, M_FRAC, M_IDENT
	} mode_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [1:0]  err;
		logic [15:0] start;
		logic [15:0] len;
		logic [15:0] line;
	} item_t;

	typedef struct packed {
		item_t [MaxResults-1:0] items;
		logic [2:0]             count;
	} bundle_t;

	typedef struct packed {
		logic    valid;
		bundle_t data;
	} head_t;

	// keyword spellings, first byte most significant
	function automatic logic [63:0] kw_spell(input logic [3:0] i);
		unique case (i)
			4'd0:  kw_spell = 64'h616E64;
			4'd1:  kw_spell = 64'h636C617373;
			4'd2:  kw_spell = 64'h656C7365;
			4'd3:  kw_spell = 64'h66616C7365;
			4'd4:  kw_spell = 64'h66756E;
			4'd5:  kw_spell = 64'h666F72;
			4'd6:  kw_spell = 64'h6966;
			4'd7:  kw_spell = 64'h6E696C;
			4'd8:  kw_spell = 64'h6F72;
			4'd9:  kw_spell = 64'h7072696E74;
			4'd10: kw_spell = 64'h72657475726E;
			4'd11: kw_spell = 64'h7375706572;
			4'd12: kw_spell = 64'h74686973;
			4'd13: kw_spell = 64'h74727565;
			4'd14: kw_spell = 64'h766172;
			default: kw_spell = 64'h7768696C65;
		endcase
	endfunction

	function automatic logic [3:0] kw_len(input logic [3:0] i);
		unique case (i)
			4'd1, 4'd3, 4'd9, 4'd11, 4'd15: kw_len = 4'd5;
			4'd2, 4'd12, 4'd13:             kw_len = 4'd4;
			4'd6, 4'd8:                     kw_len = 4'd2;
			4'd10:                          kw_len = 4'd6;
			default:                        kw_len = 4'd3;
		endcase
	endfunction

endpackage

[src/slx_char_if.sv]
// ----------------------------------------------------------------------------
// slx_char_if: source byte channel
// Valid/ready channel that carries one source byte request.
// ----------------------------------------------------------------------------
interface slx_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       char_present;
	logic       end_of_source;

	modport source (output valid, char_code, char_present, end_of_source, input ready);
	modport sink (input valid, char_code, char_present, end_of_source, output ready);
endinterface

[src/slx_token_if.sv]
// ----------------------------------------------------------------------------
// slx_token_if: token channel
// Valid/ready channel that carries one token request.
// ----------------------------------------------------------------------------
interface slx_token_if;
	logic        valid;
	logic        ready;
	logic [5:0]  kind_code;
	logic [1:0]  error_code;
	logic [15:0] start_offset;
	logic [15:0] token_length;
	logic [15:0] line_number;
	logic        last_of_run;

	modport source (output valid, kind_code, error_code, start_offset, token_length,
		line_number, last_of_run, input ready);
	modport sink (input valid, kind_code, error_code, start_offset, token_length,
		line_number, last_of_run, output ready);
endinterface

[src/slx_front.sv]
// ----------------------------------------------------------------------------
// slx_front: scanner front end
// Holds scan state, classifies each byte and builds the bundle of tokens it causes.
// ----------------------------------------------------------------------------
module slx_front import slx_pkg::*; #(
	parameter int OFFSET_BITS = 16,
	parameter int KEYWORD_MAX_LEN = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        char_present,
	input  logic        end_of_source,
	input  logic        q_full,
	output logic        push,
	output bundle_t     push_data
);
	localparam int PW = 8 * KEYWORD_MAX_LEN;
	localparam logic [OFFSET_BITS-1:0] OMAX = '1;

	mode_t                  mode_q;
	logic [OFFSET_BITS-1:0] tb_q, pos_q, lc_q, rl_q;
	logic [PW-1:0]          ip_q;

	mode_t                  mode, fmode;
	logic [OFFSET_BITS-1:0] tb, pos, lc, rl, p;
	logic [PW-1:0]          ip;
	logic                   consumed, fin, dig, alp;
	logic [2:0]             n;
	item_t [MaxResults-1:0] it;
	logic                   acc;

	function automatic logic [OFFSET_BITS-1:0] sinc(input logic [OFFSET_BITS-1:0] v);
		sinc = (v == OMAX) ? OMAX : v + 1'b1;
	endfunction

	function automatic logic [OFFSET_BITS-1:0] sadd(input logic [OFFSET_BITS-1:0] a,
		input logic [OFFSET_BITS-1:0] b);
		logic [OFFSET_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		sadd = s[OFFSET_BITS] ? OMAX : s[OFFSET_BITS-1:0];
	endfunction

	function automatic item_t mk(input logic [5:0] k, input logic [1:0] e,
		input logic [OFFSET_BITS-1:0] s, input logic [OFFSET_BITS-1:0] l,
		input logic [OFFSET_BITS-1:0] ln);
		mk.kind = k;
		mk.err = e;
		mk.start = 16'(s);
		mk.len = 16'(l);
		mk.line = 16'(ln);
	endfunction

	function automatic logic [5:0] ident_kind(input logic [PW-1:0] pre,
		input logic [OFFSET_BITS-1:0] len);
		ident_kind = K_IDENT;
		if (len <= OFFSET_BITS'(KEYWORD_MAX_LEN)) begin
			for (int i = 0; i < 16; i++) begin
				if (OFFSET_BITS'(kw_len(4'(i))) == len && PW'(kw_spell(4'(i))) == pre)
					ident_kind = K_KEYWORD0 + 6'(i);
			end
		end
	endfunction

	assign acc = in_valid && in_ready;
	assign in_ready = !q_full;
	assign push = acc && (n != 3'd0);
	assign push_data.items = it;
	assign push_data.count = n;

	always_comb begin
		mode = mode_q; tb = tb_q; pos = pos_q; lc = lc_q; rl = rl_q; ip = ip_q;
		n = 3'd0; it = '0; consumed = 1'b0; fin = 1'b0; p = pos_q; fmode = M_IDLE;
		dig = (char_code >= "0") && (char_code <= "9");
		alp = ((char_code >= "a") && (char_code <= "z")) ||
			((char_code >= "A") && (char_code <= "Z")) || (char_code == C_UNDER);
		if (char_present) begin
			unique case (mode)
				M_IDLE: ;
				M_SLASH: begin
					if (char_code == C_SLASH) begin mode = M_COMMENT; consumed = 1'b1; end
					else fin = 1'b1;
				end
				M_BANG, M_EQUAL, M_GREATER, M_LESS: begin
					if (char_code == C_EQ) begin
						it[n[1:0]] = mk(K_BANG_EQ + 6'({mode - M_BANG, 1'b0}), E_NONE, tb,
							OFFSET_BITS'(2), lc);
						n = n + 3'd1;
						mode = M_IDLE;
						consumed = 1'b1;
					end else fin = 1'b1;
				end
				M_COMMENT: begin
					if (char_code == C_NL) begin lc = sinc(lc); mode = M_IDLE; end
					consumed = 1'b1;
				end
				M_STRING: begin
					if (char_code == C_QUOTE) begin
						it[n[1:0]] = mk(K_STRING, E_NONE, tb, rl, lc);
						n = n + 3'd1;
						mode = M_IDLE;
					end else begin
						if (char_code == C_NL) lc = sinc(lc);
						rl = sinc(rl);
					end
					consumed = 1'b1;
				end
				M_INT: begin
					if (dig) begin rl = sinc(rl); consumed = 1'b1; end
					else if (char_code == C_DOT) begin mode = M_DOT; consumed = 1'b1; end
					else fin = 1'b1;
				end
				M_DOT: begin
					if (dig) begin
						rl = sadd(rl, OFFSET_BITS'(2)); mode = M_FRAC; consumed = 1'b1;
					end else fin = 1'b1;
				end
				M_FRAC: begin
					if (dig) begin rl = sinc(rl); consumed = 1'b1; end
					else fin = 1'b1;
				end
				M_IDENT: begin
					if (alp || dig) begin
						if (rl < OFFSET_BITS'(KEYWORD_MAX_LEN)) ip = {ip[PW-9:0], char_code};
						rl = sinc(rl);
						consumed = 1'b1;
					end else fin = 1'b1;
				end
				default: ;
			endcase
			if (fin) begin
				// complete the token that this byte ends, since it does not continue it
				unique case (mode)
					M_SLASH:   begin it[n[1:0]] = mk(K_SLASH, E_NONE, tb, OFFSET_BITS'(1), lc); n = n + 3'd1; end
					M_BANG:    begin it[n[1:0]] = mk(K_BANG, E_NONE, tb, OFFSET_BITS'(1), lc); n = n + 3'd1; end
					M_EQUAL:   begin it[n[1:0]] = mk(K_EQUAL, E_NONE, tb, OFFSET_BITS'(1), lc); n = n + 3'd1; end
					M_GREATER: begin it[n[1:0]] = mk(K_GREATER, E_NONE, tb, OFFSET_BITS'(1), lc); n = n + 3'd1; end
					M_LESS:    begin it[n[1:0]] = mk(K_LESS, E_NONE, tb, OFFSET_BITS'(1), lc); n = n + 3'd1; end
					M_INT, M_FRAC: begin it[n[1:0]] = mk(K_NUMBER, E_NONE, tb, rl, lc); n = n + 3'd1; end
					M_DOT: begin
						it[n[1:0]] = mk(K_NUMBER, E_NONE, tb, rl, lc); n = n + 3'd1;
						it[n[1:0]] = mk(K_DOT, E_NONE, sadd(tb, rl), OFFSET_BITS'(1), lc);
						n = n + 3'd1;
					end
					M_IDENT: begin it[n[1:0]] = mk(ident_kind(ip, rl), E_NONE, tb, rl, lc); n = n + 3'd1; end
					default: ;
				endcase
				mode = M_IDLE;
			end
			if (!consumed) begin
				tb = p;
				unique case (char_code)
					"(": begin it[n[1:0]] = mk(K_LPAREN, E_NONE, p, OFFSET_BITS'(1), lc); n = n + 3'd1; end
					")": begin it[n[1:0]] = mk(K_RPAREN, E_NONE, p, OFFSET_BITS'(1), lc); n = n + 3'd1; end
					"{": begin it[n[1:0]] = mk(K_LBRACE, E_NONE, p, OFFSET_BITS'(1), lc); n = n + 3'd1; end
					"}": begin it[n[1:0]] = mk(K_RBRACE, E_NONE, p, OFFSET_BITS'(1), lc); n = n + 3'd1; end
					",": begin it[n[1:0]] = mk(K_COMMA, E_NONE, p, OFFSET_BITS'(1), lc); n = n + 3'd1; end
					".": begin it[n[1:0]] = mk(K_DOT, E_NONE, p, OFFSET_BITS'(1), lc); n = n + 3'd1; end
					"-": begin it[n[1:0]] = mk(K_MINUS, E_NONE, p, OFFSET_BITS'(1), lc); n = n + 3'd1; end
					"+": begin it[n[1:0]] = mk(K_PLUS, E_NONE, p, OFFSET_BITS'(1), lc); n = n + 3'd1; end
					";": begin it[n[1:0]] = mk(K_SEMI, E_NONE, p, OFFSET_BITS'(1), lc); n = n + 3'd1; end
					"*": begin it[n[1:0]] = mk(K_STAR, E_NONE, p, OFFSET_BITS'(1), lc); n = n + 3'd1; end
					"/": mode = M_SLASH;
					"!": mode = M_BANG;
					"=": mode = M_EQUAL;
					">": mode = M_GREATER;
					"<": mode = M_LESS;
					C_QUOTE: begin tb = sinc(p); rl = '0; mode = M_STRING; end
					" ", 8'h09: ;
					C_NL, C_CR: lc = sinc(lc);
					default: begin
						if (dig) begin
							rl = OFFSET_BITS'(1); mode = M_INT;
						end else if (alp) begin
							rl = OFFSET_BITS'(1); ip = PW'(char_code); mode = M_IDENT;
						end else begin
							it[n[1:0]] = mk(6'd0, E_ILLEGAL, p, OFFSET_BITS'(1), lc);
							n = n + 3'd1;
						end
					end
				endcase
			end
			pos = sinc(pos);
		end
		if (end_of_source) begin
			fmode = mode;
			unique case (fmode)
				M_SLASH:   begin it[n[1:0]] = mk(K_SLASH, E_NONE, tb, OFFSET_BITS'(1), lc); n = n + 3'd1; end
				M_BANG:    begin it[n[1:0]] = mk(K_BANG, E_NONE, tb, OFFSET_BITS'(1), lc); n = n + 3'd1; end
				M_EQUAL:   begin it[n[1:0]] = mk(K_EQUAL, E_NONE, tb, OFFSET_BITS'(1), lc); n = n + 3'd1; end
				M_GREATER: begin it[n[1:0]] = mk(K_GREATER, E_NONE, tb, OFFSET_BITS'(1), lc); n = n + 3'd1; end
				M_LESS:    begin it[n[1:0]] = mk(K_LESS, E_NONE, tb, OFFSET_BITS'(1), lc); n = n + 3'd1; end
				M_STRING:  begin it[n[1:0]] = mk(6'd0, E_UNTERM, tb, rl, lc); n = n + 3'd1; end
				M_INT, M_FRAC: begin it[n[1:0]] = mk(K_NUMBER, E_NONE, tb, rl, lc); n = n + 3'd1; end
				M_DOT: begin
					it[n[1:0]] = mk(K_NUMBER, E_NONE, tb, rl, lc); n = n + 3'd1;
					it[n[1:0]] = mk(K_DOT, E_NONE, sadd(tb, rl), OFFSET_BITS'(1), lc);
					n = n + 3'd1;
				end
				M_IDENT: begin it[n[1:0]] = mk(ident_kind(ip, rl), E_NONE, tb, rl, lc); n = n + 3'd1; end
				default: ;
			endcase
			it[n[1:0]] = mk(K_EOF, E_NONE, pos, '0, lc);
			n = n + 3'd1;
			mode = M_IDLE; tb = '0; pos = '0; lc = OFFSET_BITS'(1); ip = '0; rl = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			tb_q <= '0;
			pos_q <= '0;
			lc_q <= OFFSET_BITS'(1);
			ip_q <= '0;
			rl_q <= '0;
		end else if (acc) begin
			mode_q <= mode;
			tb_q <= tb;
			pos_q <= pos;
			lc_q <= lc;
			ip_q <= ip;
			rl_q <= rl;
		end
	end
endmodule

[src/slx_queue.sv]
// ----------------------------------------------------------------------------
// slx_queue: token bundle queue
// Short queue of token bundles between the front and back parts.
// ----------------------------------------------------------------------------
module slx_queue import slx_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	input  logic    pop,
	output logic    full,
	output head_t   head
);
	bundle_t    mem_q [QueueDepth];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'(QueueDepth));
	assign head.valid = (cnt_q != 2'd0);
	assign head.data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

[src/slx_back.sv]
// ----------------------------------------------------------------------------
// slx_back: token serializer
// Takes bundles from the queue and hands out their tokens one per request.
// ----------------------------------------------------------------------------
module slx_back import slx_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  head_t        head,
	output logic         pop,
	slx_token_if.source  tok
);
	bundle_t    cur_q;
	logic [1:0] idx_q;
	logic       have_q;
	logic       last, done;
	item_t      sel;

	assign sel = cur_q.items[idx_q];
	assign last = (idx_q == 2'(cur_q.count - 3'd1));
	assign done = have_q && tok.ready && last;
	// load the next bundle when empty or when the current one drains
	assign pop = head.valid && (!have_q || done);

	assign tok.valid = have_q;
	assign tok.kind_code = sel.kind;
	assign tok.error_code = sel.err;
	assign tok.start_offset = sel.start;
	assign tok.token_length = sel.len;
	assign tok.line_number = sel.line;
	assign tok.last_of_run = last;

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			idx_q <= 2'd0;
		end else begin
			if (pop) begin
				have_q <= 1'b1;
				idx_q <= 2'd0;
			end else if (done) begin
				have_q <= 1'b0;
				idx_q <= 2'd0;
			end else if (have_q && tok.ready) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	a_count_ok: assert property (@(posedge clk) disable iff (!arst_n)
		have_q |-> (cur_q.count != 3'd0 && cur_q.count <= 3'(MaxResults)))
		else $error("bundle count out of range");
	a_idx_ok: assert property (@(posedge clk) disable iff (!arst_n)
		have_q |-> (3'(idx_q) < cur_q.count))
		else $error("token index past bundle end");
	a_pop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(have_q && !tok.ready) |-> !pop)
		else $error("bundle replaced while stalled");
endmodule

[src/script_lexer.sv]
// ----------------------------------------------------------------------------
// script_lexer: streaming scanner for a small scripting language
// Bytes in, tokens out; front classifies, queue decouples, back serializes.
// ----------------------------------------------------------------------------
// Throughput: one source byte per cycle while the token side keeps up; the
//   back end delivers one token per cycle while the token side is ready;
//   bytes that cause several tokens are absorbed by the two-entry bundle queue.
// Path: a token is written into the queue with the byte that completes it,
//   then loaded into the serializer register before it is offered.
// Reset: arst_n clears scan state (line count to one) and empties the queue.
module script_lexer import slx_pkg::*; #(
	parameter int OFFSET_BITS = 16,
	parameter int KEYWORD_MAX_LEN = 6
) (
	input logic        clk,
	input logic        arst_n,
	slx_char_if.sink   char_stream,
	slx_token_if.source token_stream
);
	logic    q_full, push, pop;
	bundle_t push_data;
	head_t   head;

	// front: hold scan state, classify each byte request, build its bundle
	slx_front #(.OFFSET_BITS(OFFSET_BITS), .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(char_stream.valid),
		.in_ready(char_stream.ready),
		.char_code(char_stream.char_code),
		.char_present(char_stream.char_present),
		.end_of_source(char_stream.end_of_source),
		.q_full(q_full),
		.push(push),
		.push_data(push_data)
	);

	// queue: let front and back stall on their own
	slx_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.full(q_full),
		.head(head)
	);

	// back: advance through each bundle one token request at a time
	slx_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.tok(token_stream)
	);
endmodule
